>>> rtl/goertzel_single_bin_dft_macros.svh
// Assertion macros for the Goertzel block. Clock and reset are taken from
// the scope of the module that uses them.
`ifndef GOERTZEL_SINGLE_BIN_DFT_MACROS_SVH
`define GOERTZEL_SINGLE_BIN_DFT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GSB_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("goertzel check failed");

// Consequent must hold in the cycle after the antecedent.
`define GSB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("goertzel check failed");

`endif

>>> rtl/gsb_pkg.sv
package gsb_pkg;

   localparam int COEF_W     = 32;
   localparam int CHUNK_W    = 32;
   localparam int MUL_B_W    = CHUNK_W + 1;
   localparam int PROD_W     = COEF_W + MUL_B_W;
   localparam int OUT_W      = 48;
   localparam int STATE_FRAC = 8;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_COS_W     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_W     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_COS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_SIN = 3'd3;

   typedef enum logic [1:0] {
      COEF_COS,
      COEF_SIN,
      COEF_PCOS,
      COEF_PSIN
   } coef_sel_type;

   typedef enum logic [1:0] {
      OPND_PREV,
      OPND_PREV2,
      OPND_YRE,
      OPND_YIM
   } opnd_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [2:0] {
      FIN_NONE,
      FIN_RECUR,
      FIN_YRE,
      FIN_YIM,
      FIN_ORE,
      FIN_OIM
   } fin_op_type;

   typedef struct packed {
      logic         take_sample;
      coef_sel_type coef_sel;
      opnd_sel_type opnd_sel;
      logic         mul_hi;
      logic         mul_sub;
      acc_op_type   acc_op;
      logic         rnd_recur;
      fin_op_type   fin_op;
      logic         emit;
   } gsb_cmd_type;

endpackage

>>> rtl/gsb_req_if.sv
interface gsb_req_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

>>> rtl/gsb_rsp_if.sv
interface gsb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic signed [gsb_pkg::OUT_W-1:0] bin_real;
   logic signed [gsb_pkg::OUT_W-1:0] bin_imag;
   logic                            saturated;

   modport source (output valid, output bin_real, output bin_imag, output saturated,
                   input ready);
   modport sink   (input valid, input bin_real, input bin_imag, input saturated,
                   output ready);
endinterface

>>> rtl/goertzel_single_bin_dft.sv
// Channel | Dir | Payload                                    | Handshake
// req     | in  | sample[SAMPLE_WIDTH] signed, last          | valid / ready
// rsp     | out | bin_real[48], bin_imag[48] signed, saturated | valid / ready
// csr     | in  | csr_index[3], csr_wdata[32]                | csr_we, never stalls
//
// A sample beat is accepted, then the single 32x33 multiplier forms two
// partial products, they are accumulated, then rounded and saturated into the state.
// The beat marked last also runs y and the phase rotation through the
// same multiplier; no new sample is taken until that work is done.
// Reset is synchronous: state cleared, coefficients back to 1.0 and 0.
// A pending result beat stalls the block only when the next bin is ready.
`include "goertzel_single_bin_dft_macros.svh"

module goertzel_single_bin_dft #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int STATE_WIDTH    = 56,
   parameter int COEF_FRAC_BITS = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   gsb_req_if.sink                       req,
   gsb_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [gsb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gsb_pkg::COEF_W-1:0]    csr_wdata
);

   // command bundle from the sequencer, one free flag back from the output
   gsb_pkg::gsb_cmd_type cmd;
   logic                 rsp_free;

   // sequencer: walks each job through issue, accumulate and finish steps
   gsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last),
      .req_ready (req.ready),
      .rsp_free  (rsp_free),
      .cmd       (cmd)
   );

   // datapath: coefficients, recurrence state, shared multiplier, accumulator
   gsb_dpath #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .STATE_WIDTH    (STATE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .req_sample    (req.sample),
      .rsp_ready     (rsp.ready),
      .rsp_valid     (rsp.valid),
      .rsp_bin_real  (rsp.bin_real),
      .rsp_bin_imag  (rsp.bin_imag),
      .rsp_saturated (rsp.saturated),
      .rsp_free      (rsp_free)
   );

   // an accepted beat keeps the input closed while it is worked on
   `GSB_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, !req.ready)
   // nothing moves in the accumulator or the state while the input is open
   `GSB_ASSERT_NOW(a_idle_quiet, req.ready, cmd.acc_op == gsb_pkg::ACC_HOLD && cmd.fin_op == gsb_pkg::FIN_NONE)
   // a bin handed over always shows on the result channel
   `GSB_ASSERT_NEXT(a_emit_valid, cmd.emit, rsp.valid)

endmodule

>>> rtl/gsb_ctrl.sv
module gsb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   input  logic                 rsp_free,
   output gsb_pkg::gsb_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_A_LO,
      ST_A_HI,
      ST_B_LO,
      ST_B_HI,
      ST_DRAIN,
      ST_FINISH,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      JOB_RECUR,
      JOB_YRE,
      JOB_YIM,
      JOB_ORE,
      JOB_OIM
   } job_type;

   state_type state_ff;
   job_type   job_ff;
   logic      last_ff;

   gsb_pkg::coef_sel_type a_coef, b_coef;
   gsb_pkg::opnd_sel_type a_opnd, b_opnd;
   logic                  b_sub;
   logic                  job_two;
   logic                  job_recur;
   gsb_pkg::fin_op_type   job_fin;

   // operand table of each job: term A, and term B for two-term jobs
   always_comb begin
      a_coef    = gsb_pkg::COEF_COS;
      a_opnd    = gsb_pkg::OPND_PREV;
      b_coef    = gsb_pkg::COEF_PSIN;
      b_opnd    = gsb_pkg::OPND_YIM;
      b_sub     = 1'b0;
      job_two   = 1'b0;
      job_recur = 1'b0;
      job_fin   = gsb_pkg::FIN_RECUR;
      unique case (job_ff)
         JOB_RECUR: begin
            job_recur = 1'b1;
         end
         JOB_YRE: begin
            a_opnd  = gsb_pkg::OPND_PREV2;
            job_fin = gsb_pkg::FIN_YRE;
         end
         JOB_YIM: begin
            a_coef  = gsb_pkg::COEF_SIN;
            a_opnd  = gsb_pkg::OPND_PREV2;
            job_fin = gsb_pkg::FIN_YIM;
         end
         JOB_ORE: begin
            a_coef  = gsb_pkg::COEF_PCOS;
            a_opnd  = gsb_pkg::OPND_YRE;
            job_two = 1'b1;
            job_fin = gsb_pkg::FIN_ORE;
         end
         JOB_OIM: begin
            a_coef  = gsb_pkg::COEF_PCOS;
            a_opnd  = gsb_pkg::OPND_YIM;
            b_opnd  = gsb_pkg::OPND_YRE;
            b_sub   = 1'b1;
            job_two = 1'b1;
            job_fin = gsb_pkg::FIN_OIM;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cmd.take_sample = 1'b0;
      cmd.coef_sel    = a_coef;
      cmd.opnd_sel    = a_opnd;
      cmd.mul_hi      = 1'b0;
      cmd.mul_sub     = 1'b0;
      cmd.acc_op      = gsb_pkg::ACC_HOLD;
      cmd.rnd_recur   = job_recur;
      cmd.fin_op      = gsb_pkg::FIN_NONE;
      cmd.emit        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take_sample = req_valid;
         end
         ST_A_LO: begin
         end
         ST_A_HI: begin
            cmd.mul_hi = 1'b1;
            cmd.acc_op = gsb_pkg::ACC_LOAD;
         end
         ST_B_LO: begin
            cmd.coef_sel = b_coef;
            cmd.opnd_sel = b_opnd;
            cmd.mul_sub  = b_sub;
            cmd.acc_op   = gsb_pkg::ACC_ADD;
         end
         ST_B_HI: begin
            cmd.coef_sel = b_coef;
            cmd.opnd_sel = b_opnd;
            cmd.mul_hi   = 1'b1;
            cmd.mul_sub  = b_sub;
            cmd.acc_op   = gsb_pkg::ACC_ADD;
         end
         ST_DRAIN: begin
            cmd.acc_op = gsb_pkg::ACC_ADD;
         end
         ST_FINISH: begin
            cmd.fin_op = job_fin;
         end
         ST_EMIT: begin
            cmd.emit = rsp_free;
         end
         default: begin
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         job_ff   <= JOB_RECUR;
         last_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  last_ff  <= req_last;
                  job_ff   <= JOB_RECUR;
                  state_ff <= ST_A_LO;
               end
            end
            ST_A_LO:  state_ff <= ST_A_HI;
            ST_A_HI:  state_ff <= job_two ? ST_B_LO : ST_DRAIN;
            ST_B_LO:  state_ff <= ST_B_HI;
            ST_B_HI:  state_ff <= ST_DRAIN;
            ST_DRAIN: state_ff <= ST_FINISH;
            ST_FINISH: begin
               unique case (job_ff)
                  JOB_RECUR: begin
                     if (last_ff) begin
                        job_ff   <= JOB_YRE;
                        state_ff <= ST_A_LO;
                     end else begin
                        state_ff <= ST_IDLE;
                     end
                  end
                  JOB_YRE: begin
                     job_ff   <= JOB_YIM;
                     state_ff <= ST_A_LO;
                  end
                  JOB_YIM: begin
                     job_ff   <= JOB_ORE;
                     state_ff <= ST_A_LO;
                  end
                  JOB_ORE: begin
                     job_ff   <= JOB_OIM;
                     state_ff <= ST_A_LO;
                  end
                  JOB_OIM: begin
                     state_ff <= ST_EMIT;
                  end
                  default: begin
                     state_ff <= ST_IDLE;
                  end
               endcase
            end
            ST_EMIT: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> rtl/gsb_dpath.sv
module gsb_dpath #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int STATE_WIDTH    = 56,
   parameter int COEF_FRAC_BITS = 30
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [gsb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gsb_pkg::COEF_W-1:0]           csr_wdata,
   input  gsb_pkg::gsb_cmd_type                 cmd,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [gsb_pkg::OUT_W-1:0]     rsp_bin_real,
   output logic signed [gsb_pkg::OUT_W-1:0]     rsp_bin_imag,
   output logic                                 rsp_saturated,
   output logic                                 rsp_free
);

   localparam int CW       = gsb_pkg::COEF_W;
   localparam int KW       = gsb_pkg::CHUNK_W;
   localparam int BW       = gsb_pkg::MUL_B_W;
   localparam int PW       = gsb_pkg::PROD_W;
   localparam int OW       = gsb_pkg::OUT_W;
   localparam int SW       = STATE_WIDTH;
   localparam int XE_W     = STATE_WIDTH + 1;
   localparam int ACC_W    = STATE_WIDTH + 34;
   localparam int SUM_W    = ACC_W + 1;
   localparam int SH_RECUR = COEF_FRAC_BITS - 1;
   localparam int SH_FULL  = COEF_FRAC_BITS;
   localparam logic signed [CW-1:0]    COEF_ONE   = CW'(64'd1 << COEF_FRAC_BITS);
   localparam logic signed [ACC_W-1:0] BIAS_RECUR = ACC_W'(1) << (SH_RECUR - 1);
   localparam logic signed [ACC_W-1:0] BIAS_FULL  = ACC_W'(1) << (SH_FULL - 1);

   // configuration
   logic signed [CW-1:0] cos_w_ff, sin_w_ff, phase_cos_ff, phase_sin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_w_ff     <= COEF_ONE;
         sin_w_ff     <= '0;
         phase_cos_ff <= COEF_ONE;
         phase_sin_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            gsb_pkg::CSR_COS_W:     cos_w_ff     <= csr_wdata;
            gsb_pkg::CSR_SIN_W:     sin_w_ff     <= csr_wdata;
            gsb_pkg::CSR_PHASE_COS: phase_cos_ff <= csr_wdata;
            gsb_pkg::CSR_PHASE_SIN: phase_sin_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // state and intermediate values
   logic signed [SW-1:0]   prev_ff, prev2_ff, yre_ff, yim_ff;
   logic signed [OW-1:0]   ore_ff, oim_ff;
   logic signed [XE_W-1:0] xe_ff, xe_in;
   logic                   sat_ff;
   logic                   rsp_valid_ff;
   logic signed [OW-1:0]   rsp_real_ff, rsp_imag_ff;
   logic                   rsp_sat_ff;

   // shared multiplier: coefficient times one chunk of a state operand, split at bit 32
   logic signed [CW-1:0]  coef_m;
   logic signed [SW-1:0]  opnd_m;
   logic signed [BW-1:0]  b_m;
   logic signed [PW-1:0]  prod_in, prod_ff;
   logic                  prod_hi_ff, prod_sub_ff;

   always_comb begin
      unique case (cmd.coef_sel)
         gsb_pkg::COEF_COS:  coef_m = cos_w_ff;
         gsb_pkg::COEF_SIN:  coef_m = sin_w_ff;
         gsb_pkg::COEF_PCOS: coef_m = phase_cos_ff;
         gsb_pkg::COEF_PSIN: coef_m = phase_sin_ff;
         default:            coef_m = cos_w_ff;
      endcase
      unique case (cmd.opnd_sel)
         gsb_pkg::OPND_PREV:  opnd_m = prev_ff;
         gsb_pkg::OPND_PREV2: opnd_m = prev2_ff;
         gsb_pkg::OPND_YRE:   opnd_m = yre_ff;
         gsb_pkg::OPND_YIM:   opnd_m = yim_ff;
         default:             opnd_m = prev_ff;
      endcase
   end

   // low chunk is unsigned, high chunk carries the sign
   assign b_m     = cmd.mul_hi ? BW'(signed'(opnd_m[SW-1:KW]))
                               : signed'({1'b0, opnd_m[KW-1:0]});
   assign prod_in = coef_m * b_m;

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      prod_hi_ff  <= cmd.mul_hi;
      prod_sub_ff <= cmd.mul_sub;
   end

   // accumulator: rounding bias plus weighted partial products
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] p_ext, p_sh, acc_base;

   assign p_ext    = ACC_W'(prod_ff);
   assign p_sh     = prod_hi_ff ? (p_ext <<< KW) : p_ext;
   assign acc_base = (cmd.acc_op == gsb_pkg::ACC_LOAD)
                     ? (cmd.rnd_recur ? BIAS_RECUR : BIAS_FULL) : acc_ff;

   always_comb begin
      unique case (cmd.acc_op)
         gsb_pkg::ACC_LOAD,
         gsb_pkg::ACC_ADD: acc_in = acc_base + (prod_sub_ff ? ~p_sh : p_sh)
                                    + ACC_W'(prod_sub_ff);
         default:          acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // finish: scale down, add or subtract the side term, saturate
   logic signed [ACC_W-1:0] shifted;
   logic signed [SUM_W-1:0] fin_e, fin_s, fin_sum;
   logic                    fin_neg;
   logic                    s_fits, o_fits;
   logic signed [SW-1:0]    s_val;
   logic signed [OW-1:0]    o_val;

   assign shifted = cmd.rnd_recur ? (acc_ff >>> SH_RECUR) : (acc_ff >>> SH_FULL);
   assign fin_s   = SUM_W'(shifted);

   always_comb begin
      fin_e   = '0;
      fin_neg = 1'b0;
      unique case (cmd.fin_op)
         gsb_pkg::FIN_RECUR: fin_e = SUM_W'(xe_ff);
         gsb_pkg::FIN_YRE: begin
            fin_e   = SUM_W'(prev_ff);
            fin_neg = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign fin_sum = fin_e + (fin_neg ? ~fin_s : fin_s) + SUM_W'(fin_neg);

   assign s_fits = (&fin_sum[SUM_W-1:SW-1]) || !(|fin_sum[SUM_W-1:SW-1]);
   assign o_fits = (&fin_sum[SUM_W-1:OW-1]) || !(|fin_sum[SUM_W-1:OW-1]);
   assign s_val  = s_fits ? fin_sum[SW-1:0]
                 : (fin_sum[SUM_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});
   assign o_val  = o_fits ? fin_sum[OW-1:0]
                 : (fin_sum[SUM_W-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}});

   // sample scaled to the state format, less the older state
   assign xe_in = XE_W'(SW'(req_sample) <<< gsb_pkg::STATE_FRAC) - XE_W'(prev2_ff);

   // recurrence state and saturation flag
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         prev2_ff <= '0;
         sat_ff   <= 1'b0;
      end else if (cmd.emit) begin
         prev_ff  <= '0;
         prev2_ff <= '0;
         sat_ff   <= 1'b0;
      end else begin
         unique case (cmd.fin_op)
            gsb_pkg::FIN_RECUR: begin
               prev2_ff <= prev_ff;
               prev_ff  <= s_val;
               sat_ff   <= sat_ff | !s_fits;
            end
            gsb_pkg::FIN_YRE,
            gsb_pkg::FIN_YIM: sat_ff <= sat_ff | !s_fits;
            gsb_pkg::FIN_ORE,
            gsb_pkg::FIN_OIM: sat_ff <= sat_ff | !o_fits;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_sample) begin
         xe_ff <= xe_in;
      end
      unique case (cmd.fin_op)
         gsb_pkg::FIN_YRE: yre_ff <= s_val;
         gsb_pkg::FIN_YIM: yim_ff <= s_val;
         gsb_pkg::FIN_ORE: ore_ff <= o_val;
         gsb_pkg::FIN_OIM: oim_ff <= o_val;
         default: begin
         end
      endcase
      if (cmd.emit) begin
         rsp_real_ff <= ore_ff;
         rsp_imag_ff <= oim_ff;
         rsp_sat_ff  <= sat_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_free      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_real  = rsp_real_ff;
   assign rsp_bin_imag  = rsp_imag_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

>>> verif/goertzel_single_bin_dft_checker.sv
module goertzel_single_bin_dft_checker #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int STATE_WIDTH    = 56,
   parameter int COEF_FRAC_BITS = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   gsb_req_if                            req,
   gsb_rsp_if                            rsp,
   input  logic                          csr_we,
   input  logic [gsb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gsb_pkg::COEF_W-1:0]    csr_wdata,
   output int                            bin_errors,
   output int                            bins_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic signed [gsb_pkg::OUT_W-1:0] bin_real;
      logic signed [gsb_pkg::OUT_W-1:0] bin_imag;
      logic                             saturated;
   } dft_bin_type;

   logic signed [gsb_pkg::COEF_W-1:0] cos_coef, sin_coef, pcos_coef, psin_coef;
   wide_type                          recur_prev, recur_prev2;
   logic                              sat_seen;
   dft_bin_type                       bins_due[$];

   initial begin
      bin_errors   = 0;
      bins_pending = 0;
   end

   function automatic wide_type mul(input wide_type a, input wide_type b);
      return a * b;
   endfunction

   // round half up, then arithmetic shift
   function automatic wide_type round_shift(input wide_type v, input int s);
      wide_type half;
      half = 1;
      half = half <<< (s - 1);
      return (v + half) >>> s;
   endfunction

   function automatic wide_type clamp(input wide_type v, input int w, output logic hit);
      wide_type top_v, bot_v, res;
      top_v = 1;
      top_v = (top_v <<< (w - 1)) - 1;
      bot_v = -top_v - 1;
      hit   = 1'b0;
      res   = v;
      if (v > top_v) begin
         hit = 1'b1;
         res = top_v;
      end else if (v < bot_v) begin
         hit = 1'b1;
         res = bot_v;
      end
      return res;
   endfunction

   task automatic goertzel_advance(input logic signed [SAMPLE_WIDTH-1:0] smp,
                                   input logic closes);
      wide_type    x, acc, yre, yim, ore, oim;
      logic        hit, flag;
      dft_bin_type bin;
      x   = smp;
      x   = x <<< gsb_pkg::STATE_FRAC;
      acc = round_shift(mul(cos_coef, recur_prev), COEF_FRAC_BITS - 1) + x - recur_prev2;
      recur_prev2 = recur_prev;
      recur_prev  = clamp(acc, STATE_WIDTH, hit);
      sat_seen    = sat_seen | hit;
      if (closes) begin
         flag = sat_seen;
         yre  = clamp(recur_prev - round_shift(mul(cos_coef, recur_prev2), COEF_FRAC_BITS),
                      STATE_WIDTH, hit);
         flag = flag | hit;
         yim  = clamp(round_shift(mul(sin_coef, recur_prev2), COEF_FRAC_BITS),
                      STATE_WIDTH, hit);
         flag = flag | hit;
         ore  = clamp(round_shift(mul(yre, pcos_coef) + mul(yim, psin_coef), COEF_FRAC_BITS),
                      gsb_pkg::OUT_W, hit);
         flag = flag | hit;
         oim  = clamp(round_shift(mul(yim, pcos_coef) - mul(yre, psin_coef), COEF_FRAC_BITS),
                      gsb_pkg::OUT_W, hit);
         flag = flag | hit;
         bin.bin_real  = ore[gsb_pkg::OUT_W-1:0];
         bin.bin_imag  = oim[gsb_pkg::OUT_W-1:0];
         bin.saturated = flag;
         bins_due.push_back(bin);
         recur_prev  = '0;
         recur_prev2 = '0;
         sat_seen    = 1'b0;
      end
   endtask

   task automatic check_bin();
      dft_bin_type want;
      if (bins_due.size() == 0) begin
         $display("%0t: bin with none due: real %0d imag %0d sat %0b",
                  $time, rsp.bin_real, rsp.bin_imag, rsp.saturated);
         bin_errors++;
      end else begin
         want = bins_due.pop_front();
         if (rsp.bin_real !== want.bin_real) begin
            $display("%0t: bin_real expected %0d, got %0d", $time, want.bin_real, rsp.bin_real);
            bin_errors++;
         end
         if (rsp.bin_imag !== want.bin_imag) begin
            $display("%0t: bin_imag expected %0d, got %0d", $time, want.bin_imag, rsp.bin_imag);
            bin_errors++;
         end
         if (rsp.saturated !== want.saturated) begin
            $display("%0t: saturated expected %0b, got %0b",
                     $time, want.saturated, rsp.saturated);
            bin_errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cos_coef    = 32'sh4000_0000;
         sin_coef    = '0;
         pcos_coef   = 32'sh4000_0000;
         psin_coef   = '0;
         recur_prev  = '0;
         recur_prev2 = '0;
         sat_seen    = 1'b0;
         bins_due.delete();
      end else begin
         if (rsp.valid && rsp.ready) check_bin();
         if (csr_we) begin
            case (csr_index)
               gsb_pkg::CSR_COS_W:     cos_coef  = csr_wdata;
               gsb_pkg::CSR_SIN_W:     sin_coef  = csr_wdata;
               gsb_pkg::CSR_PHASE_COS: pcos_coef = csr_wdata;
               gsb_pkg::CSR_PHASE_SIN: psin_coef = csr_wdata;
               default: ;
            endcase
         end
         if (req.valid && req.ready) goertzel_advance(req.sample, req.last);
      end
      bins_pending <= bins_due.size();
   end

endmodule

>>> verif/goertzel_single_bin_dft_test.sv
module goertzel_single_bin_dft_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  SAMPLE_WIDTH   = 16;
   localparam int  STATE_WIDTH    = 56;
   localparam int  COEF_FRAC_BITS = 30;
   localparam int  RANDOM_BEATS   = 1900;
   localparam int  SETTLE_CYCLES  = 8;
   localparam int  LIMIT_CYCLES   = 600000;
   localparam real PI             = 3.14159265358979323846;
   localparam real Q30_ONE        = 1073741824.0;

   // Coefficient extremes in Q1.30, plus the raw 32-bit corners
   localparam logic [gsb_pkg::COEF_W-1:0] COEF_PLUS_ONE  = 32'h4000_0000;
   localparam logic [gsb_pkg::COEF_W-1:0] COEF_MINUS_ONE = 32'hC000_0000;
   localparam logic [gsb_pkg::COEF_W-1:0] COEF_ZERO      = 32'h0000_0000;
   localparam logic [gsb_pkg::COEF_W-1:0] COEF_RAW_MAX   = 32'h7FFF_FFFF;
   localparam logic [gsb_pkg::COEF_W-1:0] COEF_RAW_MIN   = 32'h8000_0000;

   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = 16'sh8000;

   logic                          clock;
   logic                          reset;
   logic                          csr_we;
   logic [gsb_pkg::CSR_IDX_W-1:0] csr_index;
   logic [gsb_pkg::COEF_W-1:0]    csr_wdata;
   int                            bin_errors;
   int                            bins_pending;
   int                            cycles;
   int                            random_beats;

   gsb_req_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) req_if ();
   gsb_rsp_if                                rsp_if ();

   goertzel_single_bin_dft #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .STATE_WIDTH   (STATE_WIDTH),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req      (req_if),
      .rsp      (rsp_if),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   goertzel_single_bin_dft_checker #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .STATE_WIDTH   (STATE_WIDTH),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .bin_errors  (bin_errors),
      .bins_pending(bins_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mostly no gap, some short ones, the odd long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return SAMPLE_MAX;
      if (r < 20) return SAMPLE_MIN;
      if (r < 35) return SAMPLE_WIDTH'($urandom_range(0, 15) - 8);
      return SAMPLE_WIDTH'($urandom);
   endfunction

   function automatic logic [gsb_pkg::COEF_W-1:0] to_q30(input real v);
      int q;
      q = $rtoi(v * Q30_ONE + ((v >= 0.0) ? 0.5 : -0.5));
      return q;
   endfunction

   function automatic logic [gsb_pkg::COEF_W-1:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return COEF_PLUS_ONE;
         1: return COEF_MINUS_ONE;
         2: return COEF_ZERO;
         3: return COEF_RAW_MAX;
         default: return COEF_RAW_MIN;
      endcase
   endfunction

   // Drive one sample beat and hold it until the block takes it.
   // Valid stays high across back-to-back beats; drop it only for a gap.
   task automatic send_beat(input logic signed [SAMPLE_WIDTH-1:0] smp, input logic closes,
                            input bit calm);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sample <= smp;
      req_if.last   <= closes;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Drop valid and wait for every bin due to come out, then let the
   // block settle before anything touches the registers
   task automatic drain_bins();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (bins_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four coefficients back to back; sometimes follow with a
   // write to an index past the list, which the block must ignore
   task automatic write_regs(input logic [gsb_pkg::COEF_W-1:0] c,
                             input logic [gsb_pkg::COEF_W-1:0] s,
                             input logic [gsb_pkg::COEF_W-1:0] pc,
                             input logic [gsb_pkg::COEF_W-1:0] ps);
      logic [gsb_pkg::COEF_W-1:0]    vals[4];
      logic [gsb_pkg::CSR_IDX_W-1:0] idx[4];
      vals = '{c, s, pc, ps};
      idx  = '{gsb_pkg::CSR_COS_W, gsb_pkg::CSR_SIN_W, gsb_pkg::CSR_PHASE_COS,
               gsb_pkg::CSR_PHASE_SIN};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      if ($urandom_range(0, 2) == 0) begin
         csr_index <= gsb_pkg::CSR_PHASE_SIN
                      + gsb_pkg::CSR_IDX_W'(1 + $urandom_range(0, 3));
         csr_wdata <= $urandom;
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Pick a new coefficient set: a real bin half the time, otherwise
   // extremes, in-range noise or raw 32-bit values that drive saturation
   task automatic choose_setting();
      int  n, k, r;
      real w;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         n = $urandom_range(2, 64);
         k = $urandom_range(0, n - 1);
         w = 2.0 * PI * k / n;
         write_regs(to_q30($cos(w)), to_q30($sin(w)),
                    to_q30($cos(w * (n - 1))), to_q30($sin(w * (n - 1))));
      end else if (r < 70) begin
         write_regs(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
      end else if (r < 85) begin
         write_regs($urandom_range(0, 32'h8000_0000) - COEF_PLUS_ONE,
                    $urandom_range(0, 32'h8000_0000) - COEF_PLUS_ONE,
                    $urandom_range(0, 32'h8000_0000) - COEF_PLUS_ONE,
                    $urandom_range(0, 32'h8000_0000) - COEF_PLUS_ONE);
      end else begin
         write_regs($urandom, $urandom, $urandom, $urandom);
      end
   endtask

   // Result side: hold ready for a run, then stall for a random gap
   initial begin
      int run;
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         run   = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
         stall = pick_gap();
         repeat (run) begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
         repeat (stall) begin
            rsp_if.ready <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // Watchdog: end a hung run
   initial begin
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL goertzel_single_bin_dft");
      $finish;
   end

   initial begin
      int  len;
      bit  calm;
      reset         <= 1'b1;
      req_if.valid  <= 1'b0;
      req_if.sample <= '0;
      req_if.last   <= 1'b0;
      csr_we        <= 1'b0;
      csr_index     <= gsb_pkg::CSR_COS_W;
      csr_wdata     <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset coefficients, blocks of one sample at both sample extremes
      send_beat(SAMPLE_MAX, 1'b1, 1'b0);
      send_beat(SAMPLE_MIN, 1'b1, 1'b0);

      // Q1.30 extremes on every register
      drain_bins();
      write_regs(COEF_MINUS_ONE, COEF_PLUS_ONE, COEF_MINUS_ONE, COEF_PLUS_ONE);
      send_beat(SAMPLE_MIN, 1'b0, 1'b0);
      send_beat(SAMPLE_MAX, 1'b0, 1'b0);
      send_beat('0, 1'b0, 1'b0);
      send_beat(16'sd1, 1'b1, 1'b0);

      // Out-of-range coefficients: the recurrence blows up, so the state
      // and both outputs saturate
      drain_bins();
      write_regs(COEF_RAW_MIN, COEF_RAW_MAX, COEF_PLUS_ONE, COEF_MINUS_ONE);
      for (int i = 0; i < 18; i++) send_beat(SAMPLE_MAX, i == 17, 1'b1);

      // Random blocks, mostly short, reconfigured between some of them
      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         if ($urandom_range(0, 3) == 0) begin
            drain_bins();
            choose_setting();
         end
         case ($urandom_range(0, 99)) inside
            [0:79]:  len = $urandom_range(1, 12);
            [80:96]: len = $urandom_range(13, 40);
            default: len = $urandom_range(41, 100);
         endcase
         calm = ($urandom_range(0, 5) == 0);
         for (int i = 0; i < len; i++) send_beat(pick_sample(), i == len - 1, calm);
         random_beats += len;
      end

      // Wait out every bin still due, then give the block time to go quiet
      req_if.valid <= 1'b0;
      do @(posedge clock); while (bins_pending != 0);
      repeat (40) @(posedge clock);

      if (bin_errors == 0 && bins_pending == 0)
         $display("PASS goertzel_single_bin_dft");
      else
         $display("FAIL goertzel_single_bin_dft");
      $finish;
   end

endmodule

>>> goertzel_single_bin_dft.f
+incdir+rtl
rtl/gsb_pkg.sv
rtl/gsb_req_if.sv
rtl/gsb_rsp_if.sv
rtl/gsb_ctrl.sv
rtl/gsb_dpath.sv
rtl/goertzel_single_bin_dft.sv
verif/goertzel_single_bin_dft_checker.sv
verif/goertzel_single_bin_dft_test.sv
